/* src/gbws_pkg.sv */
// ----------------------------------------------------------------------------
// gbws_pkg
// Types and codes shared by the grid bilinear weight selector.
// ----------------------------------------------------------------------------
package gbws_pkg;

    typedef logic [16:0] t_weight;
    typedef logic [1:0]  t_req;
    typedef logic [1:0]  t_cfg_idx;
    typedef logic [1:0]  t_mode;

    localparam t_req REQ_LOAD_X = 2'd0;
    localparam t_req REQ_LOAD_Y = 2'd1;
    localparam t_req REQ_QUERY  = 2'd2;

    localparam t_cfg_idx CFG_AXIS_SIZE     = 2'd0;
    localparam t_cfg_idx CFG_HALF_EXTENT_X = 2'd1;
    localparam t_cfg_idx CFG_HALF_EXTENT_Y = 2'd2;

    localparam t_mode MODE_CORNER   = 2'd0;
    localparam t_mode MODE_EDGE_Y   = 2'd1;
    localparam t_mode MODE_EDGE_X   = 2'd2;
    localparam t_mode MODE_INTERIOR = 2'd3;

    localparam t_weight ONE_Q16   = 17'd65536;
    localparam int      FRAC_BITS = 16;
    localparam logic [33:0] ROUND_HALF = 34'd32768;

endpackage

/* src/grid_bilinear_weight_select.sv */
// ----------------------------------------------------------------------------
// grid_bilinear_weight_select
// Bilinear interpolation weights on a square grid of sample points.
//
// Requests enter on i_start while o_busy is low. A load request (column x or
// row y) writes one table slot and gives no results. A query request raises
// o_busy, searches the coordinate tables one entry a cycle through a
// synchronous memory read, works out the cell fraction with a 16-step
// restoring divider, then produces one, two or four results. Each result is
// shown for exactly one cycle with o_strobe high; o_last marks the final
// one. Results cannot be held off.
// Query steps: per searched axis a search, a fetch of the cell bounds and
// the divider (skipped when the fraction is 0 or 1); then per result a
// multiply and a rounding/output step. A corner query skips the search.
// The configuration channel is always ready; write it only while idle.
// Reset clears the control state and the configuration registers (axis
// size 2, half extents 0); the coordinate tables are undefined until loaded.
// ----------------------------------------------------------------------------
module grid_bilinear_weight_select #(
    parameter int MAX_AXIS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_req_type,
    input  logic [4:0]          i_slot,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_strobe,
    output logic [9:0]          o_grid_index,
    output logic [16:0]         o_weight,
    output logic                o_last
);

    localparam int AW = (MAX_AXIS > 2) ? $clog2(MAX_AXIS) : 1;
    localparam int NW = $clog2(MAX_AXIS + 1);
    localparam int IW = (2 * NW + 1 > 10) ? 2 * NW + 1 : 10;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_FRAC = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_WGT  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]            r_state;
    logic [5:0]            r_axis_size;
    logic [30:0]           r_hex;
    logic [30:0]           r_hey;

    logic signed [31:0]    r_mem_x [MAX_AXIS];
    logic signed [31:0]    r_mem_y [MAX_AXIS];
    logic signed [31:0]    r_rdata_x;
    logic signed [31:0]    r_rdata_y;

    logic signed [31:0]    r_px;
    logic signed [31:0]    r_py;
    logic                  r_xpos;
    logic                  r_ypos;
    gbws_pkg::t_mode       r_mode;
    logic                  r_ax;
    logic [NW-1:0]         r_j;
    logic [NW-1:0]         r_jd;
    logic                  r_vld;
    logic [AW-1:0]         r_u;
    logic [AW-1:0]         r_ux;
    logic [AW-1:0]         r_uy;
    logic signed [31:0]    r_c0;
    logic [32:0]           r_rem;
    logic [32:0]           r_den;
    logic [15:0]           r_q;
    logic [3:0]            r_cnt;
    gbws_pkg::t_weight     r_tx;
    gbws_pkg::t_weight     r_ty;
    logic [1:0]            r_k;
    logic [33:0]           r_prod;

    logic [NW-1:0]         n_eff;
    logic [NW-1:0]         n_m1;
    logic                  accept;
    logic                  we_x;
    logic                  we_y;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         rd_addr;
    logic signed [32:0]    xs;
    logic signed [32:0]    ys;
    logic signed [32:0]    hxs;
    logic signed [32:0]    hys;
    logic                  xoff;
    logic                  yoff;
    logic signed [31:0]    p_sel;
    logic signed [31:0]    d_sel;
    logic                  s_found;
    logic                  s_last;
    logic signed [32:0]    num;
    logic signed [32:0]    den;
    logic [33:0]           rem2;
    logic [33:0]           rem_sub;
    logic                  q_bit;
    logic                  n_done;
    gbws_pkg::t_weight     n_t;
    logic [1:0]            nres_m1;
    logic [NW-1:0]         col;
    logic [NW-1:0]         row;
    gbws_pkg::t_weight     wa;
    gbws_pkg::t_weight     wb;
    logic [IW-1:0]         idx_full;
    logic [33:0]           rounded;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != S_IDLE);
    assign accept      = i_start && !o_busy;

    always_comb begin
        if (r_axis_size < 6'd2) begin
            n_eff = NW'(2);
        end else if (32'(r_axis_size) > MAX_AXIS) begin
            n_eff = NW'(MAX_AXIS);
        end else begin
            n_eff = NW'(r_axis_size);
        end
    end
    assign n_m1 = n_eff - NW'(1);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_size <= 6'd2;
            r_hex       <= '0;
            r_hey       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                gbws_pkg::CFG_AXIS_SIZE:     r_axis_size <= i_cfg_data[5:0];
                gbws_pkg::CFG_HALF_EXTENT_X: r_hex       <= i_cfg_data[30:0];
                gbws_pkg::CFG_HALF_EXTENT_Y: r_hey       <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // coordinate tables
    assign waddr = AW'(i_slot);
    assign we_x  = accept && (i_req_type == gbws_pkg::REQ_LOAD_X) && (32'(i_slot) < MAX_AXIS);
    assign we_y  = accept && (i_req_type == gbws_pkg::REQ_LOAD_Y) && (32'(i_slot) < MAX_AXIS);

    always_comb begin
        unique case (r_state)
            S_RD0:   rd_addr = r_u - AW'(1);
            S_RD1:   rd_addr = r_u;
            default: rd_addr = r_j[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_x) begin
            r_mem_x[waddr] <= i_pos_x;
        end
        r_rdata_x <= r_mem_x[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_y) begin
            r_mem_y[waddr] <= i_pos_y;
        end
        r_rdata_y <= r_mem_y[rd_addr];
    end

    // extent test
    assign xs   = {i_pos_x[31], i_pos_x};
    assign ys   = {i_pos_y[31], i_pos_y};
    assign hxs  = {2'b00, r_hex};
    assign hys  = {2'b00, r_hey};
    assign xoff = (xs < -hxs) || (xs > hxs);
    assign yoff = (ys < -hys) || (ys > hys);

    // search and fraction
    assign p_sel   = r_ax ? r_py : r_px;
    assign d_sel   = r_ax ? r_rdata_y : r_rdata_x;
    assign s_found = r_vld && (d_sel > p_sel);
    assign s_last  = r_vld && (r_jd == n_m1);

    assign num     = {p_sel[31], p_sel} - {r_c0[31], r_c0};
    assign den     = {d_sel[31], d_sel} - {r_c0[31], r_c0};

    assign rem2    = {r_rem, 1'b0};
    assign rem_sub = rem2 - {1'b0, r_den};
    assign q_bit   = (rem2 >= {1'b0, r_den});

    always_comb begin
        n_done = 1'b0;
        n_t    = '0;
        if (r_state == S_FRAC) begin
            if (num[32] || (num == '0)) begin
                n_done = 1'b1;
            end else if (num >= den) begin
                n_done = 1'b1;
                n_t    = gbws_pkg::ONE_Q16;
            end
        end else if ((r_state == S_DIV) && (r_cnt == 4'd15)) begin
            n_done = 1'b1;
            n_t    = {1'b0, r_q[14:0], q_bit};
        end
    end

    // result selection
    always_comb begin
        col = r_xpos ? n_m1 : '0;
        row = r_ypos ? n_m1 : '0;
        wa  = gbws_pkg::ONE_Q16;
        wb  = gbws_pkg::ONE_Q16;
        nres_m1 = 2'd0;
        unique case (r_mode)
            gbws_pkg::MODE_CORNER: begin
                nres_m1 = 2'd0;
            end
            gbws_pkg::MODE_EDGE_Y: begin
                nres_m1 = 2'd1;
                row = r_k[0] ? NW'(r_uy) : NW'(r_uy - AW'(1));
                wa  = r_k[0] ? r_ty : gbws_pkg::ONE_Q16 - r_ty;
            end
            gbws_pkg::MODE_EDGE_X: begin
                nres_m1 = 2'd1;
                col = r_k[0] ? NW'(r_ux) : NW'(r_ux - AW'(1));
                wa  = r_k[0] ? r_tx : gbws_pkg::ONE_Q16 - r_tx;
            end
            gbws_pkg::MODE_INTERIOR: begin
                nres_m1 = 2'd3;
                col = r_k[0] ? NW'(r_ux) : NW'(r_ux - AW'(1));
                row = r_k[1] ? NW'(r_uy) : NW'(r_uy - AW'(1));
                wa  = r_k[0] ? r_tx : gbws_pkg::ONE_Q16 - r_tx;
                wb  = r_k[1] ? r_ty : gbws_pkg::ONE_Q16 - r_ty;
            end
            default: ;
        endcase
    end

    assign idx_full = IW'(col) * IW'(n_eff) + IW'(row);
    assign rounded  = r_prod + gbws_pkg::ROUND_HALF;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_req_type == gbws_pkg::REQ_QUERY)) begin
                        r_px   <= i_pos_x;
                        r_py   <= i_pos_y;
                        r_xpos <= (xs > hxs);
                        r_ypos <= (ys > hys);
                        r_j    <= '0;
                        r_vld  <= 1'b0;
                        r_k    <= '0;
                        if (xoff && yoff) begin
                            r_mode  <= gbws_pkg::MODE_CORNER;
                            r_state <= S_WGT;
                        end else if (xoff) begin
                            r_mode  <= gbws_pkg::MODE_EDGE_Y;
                            r_ax    <= 1'b1;
                            r_state <= S_SRCH;
                        end else if (yoff) begin
                            r_mode  <= gbws_pkg::MODE_EDGE_X;
                            r_ax    <= 1'b0;
                            r_state <= S_SRCH;
                        end else begin
                            r_mode  <= gbws_pkg::MODE_INTERIOR;
                            r_ax    <= 1'b0;
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    r_jd  <= r_j;
                    r_vld <= 1'b1;
                    if (r_j != n_m1) begin
                        r_j <= r_j + NW'(1);
                    end
                    if (s_found) begin
                        r_u     <= (r_jd == '0) ? AW'(1) : AW'(r_jd);
                        r_state <= S_RD0;
                    end else if (s_last) begin
                        r_u     <= AW'(n_m1);
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_c0    <= d_sel;
                    r_state <= S_FRAC;
                end
                S_FRAC: begin
                    r_rem   <= num;
                    r_den   <= den;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    if (!n_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? rem_sub[32:0] : rem2[32:0];
                    r_q   <= {r_q[14:0], q_bit};
                    r_cnt <= r_cnt + 4'd1;
                end
                S_WGT: begin
                    r_prod  <= 34'(wa) * 34'(wb);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    o_strobe     <= 1'b1;
                    o_grid_index <= idx_full[9:0];
                    o_weight     <= rounded[gbws_pkg::FRAC_BITS +: 17];
                    o_last       <= (r_k == nres_m1);
                    r_k          <= r_k + 2'd1;
                    r_state      <= (r_k == nres_m1) ? S_IDLE : S_WGT;
                end
                default: r_state <= S_IDLE;
            endcase
            if (n_done) begin
                if (r_ax) begin
                    r_ty <= n_t;
                    r_uy <= r_u;
                end else begin
                    r_tx <= n_t;
                    r_ux <= r_u;
                end
                if (!r_ax && (r_mode == gbws_pkg::MODE_INTERIOR)) begin
                    r_ax    <= 1'b1;
                    r_j     <= '0;
                    r_vld   <= 1'b0;
                    r_state <= S_SRCH;
                end else begin
                    r_k     <= '0;
                    r_state <= S_WGT;
                end
            end
        end
    end

    // checks
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == S_EMIT)
        else $error("result strobe without an emit cycle");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_weight <= gbws_pkg::ONE_Q16)
        else $error("weight above one");

    a_last_ends_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> r_state == S_IDLE)
        else $error("query still busy after its last result");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_rem < r_den)
        else $error("divider remainder not below divisor");

    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> (r_u != '0) && (NW'(r_u) < n_eff))
        else $error("cell index outside the grid");

endmodule
